/* sv/sha_pkg.sv */
// Package with SHA-256 constants, types and round functions.
package sha_pkg;

  localparam int unsigned WordW = 32;

  typedef logic [WordW-1:0] word_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } item_t;

  typedef enum logic [4:0] {
    StIdle   = 5'b00001,
    StRound  = 5'b00010,
    StFold   = 5'b00100,
    StEmit   = 5'b01000,
    StPad    = 5'b10000
  } core_state_e;

  function automatic word_t init_hash(input logic [2:0] idx);
    word_t r;
    case (idx)
      3'd0: r = 32'h6A09E667;
      3'd1: r = 32'hBB67AE85;
      3'd2: r = 32'h3C6EF372;
      3'd3: r = 32'hA54FF53A;
      3'd4: r = 32'h510E527F;
      3'd5: r = 32'h9B05688C;
      3'd6: r = 32'h1F83D9AB;
      default: r = 32'h5BE0CD19;
    endcase
    return r;
  endfunction

  function automatic word_t round_k(input logic [5:0] t);
    word_t r;
    case (t)
      6'd0: r = 32'h428A2F98; 6'd1: r = 32'h71374491; 6'd2: r = 32'hB5C0FBCF;
      6'd3: r = 32'hE9B5DBA5; 6'd4: r = 32'h3956C25B; 6'd5: r = 32'h59F111F1;
      6'd6: r = 32'h923F82A4; 6'd7: r = 32'hAB1C5ED5; 6'd8: r = 32'hD807AA98;
      6'd9: r = 32'h12835B01; 6'd10: r = 32'h243185BE; 6'd11: r = 32'h550C7DC3;
      6'd12: r = 32'h72BE5D74; 6'd13: r = 32'h80DEB1FE; 6'd14: r = 32'h9BDC06A7;
      6'd15: r = 32'hC19BF174; 6'd16: r = 32'hE49B69C1; 6'd17: r = 32'hEFBE4786;
      6'd18: r = 32'h0FC19DC6; 6'd19: r = 32'h240CA1CC; 6'd20: r = 32'h2DE92C6F;
      6'd21: r = 32'h4A7484AA; 6'd22: r = 32'h5CB0A9DC; 6'd23: r = 32'h76F988DA;
      6'd24: r = 32'h983E5152; 6'd25: r = 32'hA831C66D; 6'd26: r = 32'hB00327C8;
      6'd27: r = 32'hBF597FC7; 6'd28: r = 32'hC6E00BF3; 6'd29: r = 32'hD5A79147;
      6'd30: r = 32'h06CA6351; 6'd31: r = 32'h14292967; 6'd32: r = 32'h27B70A85;
      6'd33: r = 32'h2E1B2138; 6'd34: r = 32'h4D2C6DFC; 6'd35: r = 32'h53380D13;
      6'd36: r = 32'h650A7354; 6'd37: r = 32'h766A0ABB; 6'd38: r = 32'h81C2C92E;
      6'd39: r = 32'h92722C85; 6'd40: r = 32'hA2BFE8A1; 6'd41: r = 32'hA81A664B;
      6'd42: r = 32'hC24B8B70; 6'd43: r = 32'hC76C51A3; 6'd44: r = 32'hD192E819;
      6'd45: r = 32'hD6990624; 6'd46: r = 32'hF40E3585; 6'd47: r = 32'h106AA070;
      6'd48: r = 32'h19A4C116; 6'd49: r = 32'h1E376C08; 6'd50: r = 32'h2748774C;
      6'd51: r = 32'h34B0BCB5; 6'd52: r = 32'h391C0CB3; 6'd53: r = 32'h4ED8AA4A;
      6'd54: r = 32'h5B9CCA4F; 6'd55: r = 32'h682E6FF3; 6'd56: r = 32'h748F82EE;
      6'd57: r = 32'h78A5636F; 6'd58: r = 32'h84C87814; 6'd59: r = 32'h8CC70208;
      6'd60: r = 32'h90BEFFFA; 6'd61: r = 32'hA4506CEB; 6'd62: r = 32'hBEF9A3F7;
      default: r = 32'hC67178F2;
    endcase
    return r;
  endfunction

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (WordW - n));
  endfunction

endpackage

/* sv/sha_fifo.sv */
// Two-entry item queue between the byte front end and the hash core.
module sha_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  sha_pkg::item_t in_item_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output sha_pkg::item_t out_item_o
);

  sha_pkg::item_t mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;
  assign out_item_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count out of range");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 && !pop |=> cnt_q == 2'd2)
    else $error("queue lost an entry");
  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd0 |=> cnt_q != 2'd2)
    else $error("queue grew by two from empty");

endmodule

/* sv/sha_core.sv */
// Hash core: packs bytes, pads, runs the 64-round compression and emits the digest.
module sha_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            item_valid_i,
  output logic            item_ready_o,
  input  sha_pkg::item_t  item_i,
  output logic            dig_valid_o,
  input  logic            dig_ready_i,
  output sha_pkg::word_t  dig_word_o,
  output logic [2:0]      dig_num_o,
  output logic            dig_last_o
);

  sha_pkg::core_state_e state_q, state_d;
  sha_pkg::word_t hash_q [8];
  sha_pkg::word_t w_q [16];
  sha_pkg::word_t a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;
  logic [5:0]  fill_q;
  logic [60:0] len_q;
  logic [5:0]  rnd_q;
  logic [2:0]  cnt_q;
  logic        fin_q;
  logic        pad_q;
  logic        padlen_q;

  sha_pkg::word_t wt, w16, s0, s1, big0, big1, ch, maj, t1, t2;
  logic [63:0] bits;
  logic        take;
  logic [5:0]  put_pos;
  logic [7:0]  put_byte;
  logic        put_en;

  assign item_ready_o = (state_q == sha_pkg::StIdle);
  assign take = item_valid_i && item_ready_o;

  assign wt   = w_q[0];
  assign s0   = sha_pkg::rotr(w_q[1], 7) ^ sha_pkg::rotr(w_q[1], 18) ^ (w_q[1] >> 3);
  assign s1   = sha_pkg::rotr(w_q[14], 17) ^ sha_pkg::rotr(w_q[14], 19) ^ (w_q[14] >> 10);
  assign w16  = s1 + w_q[9] + s0 + w_q[0];
  assign big1 = sha_pkg::rotr(e_q, 6) ^ sha_pkg::rotr(e_q, 11) ^ sha_pkg::rotr(e_q, 25);
  assign ch   = (e_q & f_q) ^ (~e_q & g_q);
  assign t1   = h_q + big1 + ch + sha_pkg::round_k(rnd_q) + wt;
  assign big0 = sha_pkg::rotr(a_q, 2) ^ sha_pkg::rotr(a_q, 13) ^ sha_pkg::rotr(a_q, 22);
  assign maj  = (a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q);
  assign t2   = big0 + maj;
  assign bits = {len_q, 3'b000};

  assign dig_valid_o = (state_q == sha_pkg::StEmit);
  assign dig_word_o  = hash_q[cnt_q];
  assign dig_num_o   = cnt_q;
  assign dig_last_o  = (cnt_q == 3'd7);

  always_comb begin
    put_en   = 1'b0;
    put_byte = 8'h00;
    put_pos  = fill_q;
    if (take && item_i.byte_present) begin
      put_en   = 1'b1;
      put_byte = item_i.data_byte;
    end else if (state_q == sha_pkg::StPad && !padlen_q) begin
      put_en   = 1'b1;
      put_byte = fin_q ? 8'h80 : 8'h00;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      sha_pkg::StIdle: begin
        if (take) begin
          if (item_i.byte_present && fill_q == 6'd63) state_d = sha_pkg::StRound;
          else if (item_i.end_of_message) state_d = sha_pkg::StPad;
        end
      end
      sha_pkg::StPad: begin
        if (padlen_q) state_d = sha_pkg::StRound;
        else if (fill_q == 6'd63) state_d = sha_pkg::StRound;
      end
      sha_pkg::StRound: begin
        if (rnd_q == 6'd63) state_d = sha_pkg::StFold;
      end
      sha_pkg::StFold: begin
        if (padlen_q) state_d = sha_pkg::StEmit;
        else if (fin_q || pad_q) state_d = sha_pkg::StPad;
        else state_d = sha_pkg::StIdle;
      end
      sha_pkg::StEmit: begin
        if (dig_ready_i && cnt_q == 3'd7) state_d = sha_pkg::StIdle;
      end
      default: state_d = sha_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (put_en) begin
      case (put_pos[1:0])
        2'd0: w_q[put_pos[5:2]][31:24] <= put_byte;
        2'd1: w_q[put_pos[5:2]][23:16] <= put_byte;
        2'd2: w_q[put_pos[5:2]][15:8]  <= put_byte;
        default: w_q[put_pos[5:2]][7:0] <= put_byte;
      endcase
    end else if (state_q == sha_pkg::StPad && padlen_q) begin
      w_q[14] <= bits[63:32];
      w_q[15] <= bits[31:0];
    end else if (state_q == sha_pkg::StRound) begin
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[15] <= w16;
    end
    if (state_q == sha_pkg::StRound) begin
      h_q <= g_q; g_q <= f_q; f_q <= e_q; e_q <= d_q + t1;
      d_q <= c_q; c_q <= b_q; b_q <= a_q; a_q <= t1 + t2;
    end else if (state_d == sha_pkg::StRound) begin
      a_q <= hash_q[0]; b_q <= hash_q[1]; c_q <= hash_q[2]; d_q <= hash_q[3];
      e_q <= hash_q[4]; f_q <= hash_q[5]; g_q <= hash_q[6]; h_q <= hash_q[7];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sha_pkg::StIdle;
      fill_q   <= '0;
      len_q    <= '0;
      rnd_q    <= '0;
      cnt_q    <= '0;
      fin_q    <= 1'b0;
      pad_q    <= 1'b0;
      padlen_q <= 1'b0;
      for (int i = 0; i < 8; i++) hash_q[i] <= sha_pkg::init_hash(3'(i));
    end else begin
      state_q <= state_d;
      if (put_en) fill_q <= fill_q + 6'd1;
      if (take && item_i.byte_present) len_q <= len_q + 61'd1;
      if (take && item_i.end_of_message) fin_q <= 1'b1;
      if (state_q == sha_pkg::StPad) pad_q <= 1'b1;
      if (state_q == sha_pkg::StPad && !padlen_q) begin
        fin_q <= 1'b0;
        if (fill_q == 6'd55) padlen_q <= 1'b1;
      end
      if (state_q == sha_pkg::StRound) rnd_q <= rnd_q + 6'd1;
      if (state_q == sha_pkg::StFold) begin
        hash_q[0] <= hash_q[0] + a_q; hash_q[1] <= hash_q[1] + b_q;
        hash_q[2] <= hash_q[2] + c_q; hash_q[3] <= hash_q[3] + d_q;
        hash_q[4] <= hash_q[4] + e_q; hash_q[5] <= hash_q[5] + f_q;
        hash_q[6] <= hash_q[6] + g_q; hash_q[7] <= hash_q[7] + h_q;
      end
      if (state_q == sha_pkg::StPad && padlen_q) fill_q <= '0;
      if (state_q == sha_pkg::StEmit && dig_ready_i) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == 3'd7) begin
          padlen_q <= 1'b0;
          pad_q    <= 1'b0;
          len_q    <= '0;
          for (int i = 0; i < 8; i++) hash_q[i] <= sha_pkg::init_hash(3'(i));
        end
      end
    end
  end

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_rounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sha_pkg::StRound && rnd_q != 6'd63 |=> state_q == sha_pkg::StRound)
    else $error("compression left early");
  a_emit_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sha_pkg::StEmit && dig_ready_i && cnt_q == 3'd7 |=> fill_q == 6'd0)
    else $error("block fill not cleared after digest");
  a_fold_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sha_pkg::StFold |-> rnd_q == 6'd0)
    else $error("round counter misaligned");

endmodule

/* sv/sha256_stream_hash_top.sv */
// Top level of the byte-stream SHA-256 hasher.
//  channel  dir  tdata                              tuser           tlast
//  s_axis   in   [7:0] data_byte                    [0] byte_present  end_of_message
//  m_axis   out  [31:0] digest_word, [34:32] word_number  -           final_word
// The core takes a byte only while idle; a full block then stalls it through the round and fold states.
// Ending a message adds the pad bytes, then the length, then one or two compressions, and
// eight output words, which output back pressure can hold up.
// Reset clears the queue and restores the initial hash value.
// A two-entry queue holds up to two transactions while the core compresses or output stalls.
module sha256_stream_hash_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic        s_axis_tuser,  // [0] byte_present
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // [31:0] digest_word, [34:32] word_number, zero fill
  output logic        m_axis_tlast
);

  sha_pkg::item_t in_item, q_item;
  logic q_valid, q_ready;
  sha_pkg::word_t dw;
  logic [2:0] dn;

  assign in_item.data_byte      = s_axis_tdata;
  assign in_item.byte_present   = s_axis_tuser;
  assign in_item.end_of_message = s_axis_tlast;

  sha_fifo u_fifo (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_item_i(in_item),
    .out_valid_o(q_valid), .out_ready_i(q_ready), .out_item_o(q_item)
  );

  sha_core u_core (
    .clk_i, .rst_ni,
    .item_valid_i(q_valid), .item_ready_o(q_ready), .item_i(q_item),
    .dig_valid_o(m_axis_tvalid), .dig_ready_i(m_axis_tready),
    .dig_word_o(dw), .dig_num_o(dn), .dig_last_o(m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0, dn, dw};

endmodule
